### sv/sacf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacf_pkg
// Shared types and constants of the set-associative cache timing block.
// ----------------------------------------------------------------------------
package sacf_pkg;

  localparam int OFFSET_BITS_DEF = 4;
  localparam int SET_BITS_DEF    = 6;
  localparam int WAYS_DEF        = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int COST_W     = 17;
  localparam int CNT_W      = 32;

  localparam logic [CFG_IDX_W-1:0] REG_HIT_TIME       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_READ_TIME  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_WRITE_TIME = 2'd2;

  localparam logic [CFG_DATA_W-1:0] HIT_TIME_RST       = 16'd1;
  localparam logic [CFG_DATA_W-1:0] MEM_READ_TIME_RST  = 16'd60;
  localparam logic [CFG_DATA_W-1:0] MEM_WRITE_TIME_RST = 16'd60;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] address;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic [COST_W-1:0] access_cost;
    logic [CNT_W-1:0]  total_time;
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  miss_count;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;   // write an empty row at the sweep address
    logic load;    // capture the incoming transaction
    logic lookup;  // read the tag row of the captured set
    logic commit;  // update totals (and the row on a read miss), load the result
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### sv/sacf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacf_ctrl
// Sequencer: clears the tag store after reset, then runs each access
// through capture, row read and compare/commit.
// ----------------------------------------------------------------------------
module sacf_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  sacf_pkg::dp_stat_t  stat,
  output sacf_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CMP
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.lookup = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        // hold until the result register can take the new result
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### sv/sacf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacf_datapath
// Tag store, FIFO victim choice, cost and saturating totals, result register.
// ----------------------------------------------------------------------------
module sacf_datapath #(
  parameter int OFFSET_BITS = sacf_pkg::OFFSET_BITS_DEF,
  parameter int SET_BITS    = sacf_pkg::SET_BITS_DEF,
  parameter int WAYS        = sacf_pkg::WAYS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  sacf_pkg::ctl_cmd_t                   cmd,
  output sacf_pkg::dp_stat_t                   stat,
  input  sacf_pkg::in_t                        in_data,
  input  wire                                  cfg_valid,
  input  wire [sacf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [sacf_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output sacf_pkg::out_t                       out_data
);

  localparam int TAG_W = 32 - OFFSET_BITS - SET_BITS;
  localparam int IDX_W = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int DEPTH = 1 << IDX_W;
  localparam int PTR_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CW    = sacf_pkg::COST_W;
  localparam int NW    = sacf_pkg::CNT_W;
  localparam int DW    = sacf_pkg::CFG_DATA_W;

  // tag store: one row per set
  logic [WAYS-1:0][TAG_W-1:0] tag_mem   [DEPTH];
  logic [WAYS-1:0]            valid_mem [DEPTH];
  logic [PTR_W-1:0]           fp_mem    [DEPTH];

  logic [WAYS-1:0][TAG_W-1:0] rd_tags;
  logic [WAYS-1:0]            rd_valid;
  logic [PTR_W-1:0]           rd_fp;

  logic        func_q;
  logic [31:0] addr_q;
  logic [DW-1:0] hit_time;
  logic [DW-1:0] mem_read_time;
  logic [DW-1:0] mem_write_time;
  logic [IDX_W-1:0] clr_addr;
  logic [NW-1:0] time_sum;
  logic [NW-1:0] hits_sum;
  logic [NW-1:0] misses_sum;

  logic [IDX_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  logic             hit;
  logic             found;
  logic [PTR_W-1:0] victim;
  logic [PTR_W-1:0] fp_new;
  logic [WAYS-1:0][TAG_W-1:0] tags_new;
  logic [WAYS-1:0]            valid_new;
  logic [CW-1:0]    cost;
  logic [NW:0]      time_add;
  logic [NW-1:0]    time_sum_next;
  logic [NW-1:0]    hits_sum_next;
  logic [NW-1:0]    misses_sum_next;
  logic             fill;
  logic             mem_we;
  logic [IDX_W-1:0] wr_addr;

  generate
    if (SET_BITS > 0) begin : g_set
      assign set_q = addr_q[OFFSET_BITS +: IDX_W];
    end else begin : g_noset
      assign set_q = '0;
    end
  endgenerate

  assign tag_q = addr_q[31 -: TAG_W];

  always_comb begin
    hit    = 1'b0;
    found  = 1'b0;
    victim = rd_fp;
    for (int w = 0; w < WAYS; w++) begin
      if (rd_valid[w] && (rd_tags[w] == tag_q)) begin
        hit = 1'b1;
      end
    end
    // first free way wins over the FIFO pointer
    for (int w = 0; w < WAYS; w++) begin
      if (!found && !rd_valid[w]) begin
        victim = PTR_W'(w);
        found  = 1'b1;
      end
    end
    fp_new = (victim == PTR_W'(WAYS - 1)) ? '0 : victim + 1'b1;
    tags_new          = rd_tags;
    tags_new[victim]  = tag_q;
    valid_new         = rd_valid;
    valid_new[victim] = 1'b1;
  end

  always_comb begin
    if (func_q == sacf_pkg::FUNC_WRITE) begin
      cost = CW'(mem_write_time);
    end else if (hit) begin
      cost = CW'(1);
    end else begin
      cost = CW'(hit_time) + CW'(mem_read_time);
    end
    time_add        = {1'b0, time_sum} + (NW + 1)'(cost);
    time_sum_next   = time_add[NW] ? '1 : time_add[NW-1:0];
    hits_sum_next   = (hit && !(&hits_sum)) ? hits_sum + 1'b1 : hits_sum;
    misses_sum_next = (!hit && !(&misses_sum)) ? misses_sum + 1'b1 : misses_sum;
  end

  assign fill    = cmd.commit && !hit && (func_q == sacf_pkg::FUNC_READ);
  assign mem_we  = cmd.clear || fill;
  assign wr_addr = cmd.clear ? clr_addr : set_q;

  assign stat.clear_last = &clr_addr;
  assign stat.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[wr_addr]   <= tags_new;
      valid_mem[wr_addr] <= cmd.clear ? '0 : valid_new;
      fp_mem[wr_addr]    <= cmd.clear ? '0 : fp_new;
    end
    if (cmd.lookup) begin
      rd_tags  <= tag_mem[set_q];
      rd_valid <= valid_mem[set_q];
      rd_fp    <= fp_mem[set_q];
    end
    if (cmd.load) begin
      func_q <= in_data.func;
      addr_q <= in_data.address;
    end
    if (cmd.commit) begin
      out_data.hit         <= hit;
      out_data.access_cost <= cost;
      out_data.total_time  <= time_sum_next;
      out_data.hit_count   <= hits_sum_next;
      out_data.miss_count  <= misses_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_time       <= sacf_pkg::HIT_TIME_RST;
      mem_read_time  <= sacf_pkg::MEM_READ_TIME_RST;
      mem_write_time <= sacf_pkg::MEM_WRITE_TIME_RST;
      clr_addr       <= '0;
      time_sum       <= '0;
      hits_sum       <= '0;
      misses_sum     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          sacf_pkg::REG_HIT_TIME:       hit_time       <= cfg_data;
          sacf_pkg::REG_MEM_READ_TIME:  mem_read_time  <= cfg_data;
          sacf_pkg::REG_MEM_WRITE_TIME: mem_write_time <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.clear) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.commit) begin
        time_sum   <= time_sum_next;
        hits_sum   <= hits_sum_next;
        misses_sum <= misses_sum_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### sv/set_assoc_cache_fifo_timing.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_timing
// Timing model of a set-associative, write-through, no-write-allocate cache
// with FIFO replacement.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one access per transaction (func, address).
//   out_* : one result per access (hit, cost, running time/hit/miss totals).
//   cfg_* : register writes (0 hit_time, 1 mem_read_time, 2 mem_write_time),
//           always ready; write only while no access is in flight.
// Path: the access is captured, then its tag row is read from the
//   single-port tag store, then compare and commit load the result.
// Flow: one access at a time, set by the read-then-update pass
//   over the tag store row; a new access is taken while the previous
//   result still sits in the output register.
// Reset: counters and registers return to their defaults, then a sweep
//   clears every tag store row, one per cycle, 2**max(SET_BITS,1) rows
//   (64 at the default size); in_ready is low during the sweep.
// Stall: a result not taken holds in the output register; an access in
//   progress waits in its compare step until the register frees up.
// ----------------------------------------------------------------------------
module set_assoc_cache_fifo_timing #(
  parameter int OFFSET_BITS = sacf_pkg::OFFSET_BITS_DEF,
  parameter int SET_BITS    = sacf_pkg::SET_BITS_DEF,
  parameter int WAYS        = sacf_pkg::WAYS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  sacf_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  wire                             out_ready,
  output sacf_pkg::out_t                  out_data,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [sacf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [sacf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  sacf_pkg::ctl_cmd_t cmd;
  sacf_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  sacf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sacf_datapath #(
    .OFFSET_BITS (OFFSET_BITS),
    .SET_BITS    (SET_BITS),
    .WAYS        (WAYS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### sv/sacf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacf_checker
// Port-level checks of the cache timing block, bound to the top level.
// ----------------------------------------------------------------------------
module sacf_checker (
  input wire            clk,
  input wire            rst,
  input wire            in_valid,
  input wire            in_ready,
  input wire            out_valid,
  input wire            out_ready,
  input sacf_pkg::out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one access at a time: no accept in the cycle after an accept
  a_seq: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted back-to-back accesses");

  a_hit_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.hit |-> out_data.hit_count != '0)
    else $error("hit reported with zero hit count");

  a_miss_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hit |-> out_data.miss_count != '0)
    else $error("miss reported with zero miss count");

  // running total always covers the latest cost
  a_total: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.total_time >= 32'(out_data.access_cost))
    else $error("total time below access cost");

endmodule

bind set_assoc_cache_fifo_timing sacf_checker u_sacf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set-associative cache timing block: directed
// fills, hits, FIFO replacement and write misses, then phases of random
// accesses over a few hot sets and tags under varied timing registers and
// handshake idling, closing with costly read misses at the largest timings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int OFF_W  = sacf_pkg::OFFSET_BITS_DEF;
  localparam int SET_W  = sacf_pkg::SET_BITS_DEF;
  localparam int NWAYS  = sacf_pkg::WAYS_DEF;
  localparam int NSETS  = 1 << SET_W;
  localparam int TAG_W  = 32 - OFF_W - SET_W;
  localparam int PHASES = 8;
  localparam int PHASE_LEN = 150;
  localparam int DW     = sacf_pkg::CFG_DATA_W;
  localparam int IW     = sacf_pkg::CFG_IDX_W;
  localparam int NW     = sacf_pkg::CNT_W;
  localparam int CW     = sacf_pkg::COST_W;

  // Predicts every access result and checks the block's results in order.
  class cache_timing_model;
    logic [DW-1:0]    hit_time;
    logic [DW-1:0]    mem_read_time;
    logic [DW-1:0]    mem_write_time;
    bit               line_valid[NSETS*NWAYS];
    bit [TAG_W-1:0]   line_tag[NSETS*NWAYS];
    int unsigned      fill_ptr[NSETS];
    logic [NW-1:0]    time_sum;
    logic [NW-1:0]    hits_sum;
    logic [NW-1:0]    misses_sum;
    sacf_pkg::out_t   expected_results[$];
    int               errors;

    function new();
      hit_time       = sacf_pkg::HIT_TIME_RST;
      mem_read_time  = sacf_pkg::MEM_READ_TIME_RST;
      mem_write_time = sacf_pkg::MEM_WRITE_TIME_RST;
      time_sum       = '0;
      hits_sum       = '0;
      misses_sum     = '0;
      errors         = 0;
    endfunction

    function logic [NW-1:0] sat_add(logic [NW-1:0] a, logic [NW-1:0] b);
      logic [NW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[NW] ? '1 : s[NW-1:0];
    endfunction

    function void set_reg(logic [IW-1:0] idx, logic [DW-1:0] val);
      case (idx)
        sacf_pkg::REG_HIT_TIME:       hit_time = val;
        sacf_pkg::REG_MEM_READ_TIME:  mem_read_time = val;
        sacf_pkg::REG_MEM_WRITE_TIME: mem_write_time = val;
        default: ;
      endcase
    endfunction

    function void note_access(sacf_pkg::in_t acc);
      int unsigned       set_idx;
      int unsigned       base;
      int unsigned       victim;
      bit [TAG_W-1:0]    tag;
      bit                found;
      logic [CW-1:0]     cost;
      sacf_pkg::out_t    res;
      set_idx = (acc.address >> OFF_W) & (NSETS - 1);
      tag     = TAG_W'(acc.address >> (OFF_W + SET_W));
      base    = set_idx * NWAYS;
      found   = 1'b0;
      for (int w = 0; w < NWAYS; w++) begin
        if (line_valid[base+w] && line_tag[base+w] == tag) found = 1'b1;
      end
      if (found) begin
        hits_sum = sat_add(hits_sum, 1);
        cost = (acc.func == sacf_pkg::FUNC_WRITE) ? {1'b0, mem_write_time} : CW'(1);
      end else begin
        misses_sum = sat_add(misses_sum, 1);
        if (acc.func == sacf_pkg::FUNC_WRITE) begin
          cost = {1'b0, mem_write_time};
        end else begin
          // lowest free way wins, else the FIFO victim
          victim = fill_ptr[set_idx];
          for (int w = NWAYS - 1; w >= 0; w--) begin
            if (!line_valid[base+w]) victim = w;
          end
          line_valid[base+victim] = 1'b1;
          line_tag[base+victim]   = tag;
          fill_ptr[set_idx]       = (victim + 1) % NWAYS;
          cost = {1'b0, hit_time} + {1'b0, mem_read_time};
        end
      end
      time_sum = sat_add(time_sum, NW'(cost));
      res.hit         = found;
      res.access_cost = cost;
      res.total_time  = time_sum;
      res.hit_count   = hits_sum;
      res.miss_count  = misses_sum;
      expected_results.push_back(res);
    endfunction

    function void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (act_val !== exp_val) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(sacf_pkg::out_t act);
      sacf_pkg::out_t exp_res;
      if (expected_results.size() == 0) begin
        $error("result with no access pending: 0x%0h", act);
        errors++;
        return;
      end
      exp_res = expected_results.pop_front();
      check_field("hit", 32'(exp_res.hit), 32'(act.hit));
      check_field("access_cost", 32'(exp_res.access_cost), 32'(act.access_cost));
      check_field("total_time", exp_res.total_time, act.total_time);
      check_field("hit_count", exp_res.hit_count, act.hit_count);
      check_field("miss_count", exp_res.miss_count, act.miss_count);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  sacf_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  sacf_pkg::out_t out_data;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [IW-1:0]  cfg_index = '0;
  logic [DW-1:0]  cfg_data  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  bit [TAG_W-1:0] hot_tag[12];
  bit [SET_W-1:0] hot_set[4];

  cache_timing_model sb = new();

  set_assoc_cache_fifo_timing #(
    .OFFSET_BITS(OFF_W),
    .SET_BITS   (SET_W),
    .WAYS       (NWAYS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_access(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  function automatic sacf_pkg::in_t make_access(logic func, bit [TAG_W-1:0] tag,
                                                bit [SET_W-1:0] set_idx,
                                                bit [OFF_W-1:0] off);
    sacf_pkg::in_t acc;
    acc.func    = func;
    acc.address = {tag, set_idx, off};
    return acc;
  endfunction

  // Mostly hot sets and tags, so lines hit, fill and get replaced.
  function automatic sacf_pkg::in_t rand_access();
    sacf_pkg::in_t  acc;
    logic           func;
    bit [SET_W-1:0] set_idx;
    func = ($urandom_range(0, 99) < 30) ? sacf_pkg::FUNC_WRITE : sacf_pkg::FUNC_READ;
    if ($urandom_range(0, 99) < 10) begin
      acc.func    = func;
      acc.address = $urandom;
      return acc;
    end
    set_idx = ($urandom_range(0, 99) < 75) ? hot_set[$urandom_range(0, 3)]
                                           : SET_W'($urandom_range(0, NSETS - 1));
    return make_access(func, hot_tag[$urandom_range(0, 11)], set_idx, OFF_W'($urandom));
  endfunction

  task automatic send_access(input sacf_pkg::in_t acc);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = acc;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Hold off new accesses until every expected result has come back.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_timing(input logic [DW-1:0] hit_t,
                            input logic [DW-1:0] rd_t,
                            input logic [DW-1:0] wr_t);
    drain();
    write_reg(sacf_pkg::REG_HIT_TIME, hit_t);
    write_reg(sacf_pkg::REG_MEM_READ_TIME, rd_t);
    write_reg(sacf_pkg::REG_MEM_WRITE_TIME, wr_t);
  endtask

  initial begin
    int pause_at;
    logic [DW-1:0] ht, rt, wt;

    hot_tag[0] = '0;
    hot_tag[1] = '1;
    for (int i = 2; i < 12; i++) hot_tag[i] = TAG_W'($urandom);
    hot_set[0] = '0;
    hot_set[1] = '1;
    hot_set[2] = SET_W'($urandom);
    hot_set[3] = SET_W'($urandom);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset timing values, one set filled then replaced in FIFO order.
    send_access(make_access(sacf_pkg::FUNC_READ, '0, '0, '0));
    send_access(make_access(sacf_pkg::FUNC_READ, '0, '0, '0));
    send_access(make_access(sacf_pkg::FUNC_WRITE, '0, '0, '1));
    send_access(make_access(sacf_pkg::FUNC_WRITE, '1, '1, '1));
    send_access(make_access(sacf_pkg::FUNC_READ, '1, '1, '1));
    send_access(make_access(sacf_pkg::FUNC_READ, '1, '1, '0));
    for (int t = 1; t <= NWAYS; t++) begin
      send_access(make_access(sacf_pkg::FUNC_READ, TAG_W'(t), SET_W'(5), OFF_W'(3)));
    end
    send_access(make_access(sacf_pkg::FUNC_READ, TAG_W'(9), SET_W'(5), '0));
    send_access(make_access(sacf_pkg::FUNC_READ, TAG_W'(1), SET_W'(5), '0));
    send_access(make_access(sacf_pkg::FUNC_READ, TAG_W'(3), SET_W'(5), '1));
    send_access(make_access(sacf_pkg::FUNC_WRITE, TAG_W'(2), SET_W'(5), '0));
    send_access(make_access(sacf_pkg::FUNC_READ, TAG_W'(9), SET_W'(5), OFF_W'(7)));
    send_access(make_access(sacf_pkg::FUNC_WRITE, '1, SET_W'(5), '1));

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin ht = '0;      rt = '0;      wt = '0;      end
        1: begin ht = '1;      rt = '1;      wt = '1;      end
        3: begin ht = 16'd1;   rt = 16'd60;  wt = 16'd60;  end
        4: begin ht = '1;      rt = '0;      wt = 16'd1;   end
        5: begin ht = '0;      rt = '1;      wt = '1;      end
        default: begin
          ht = DW'($urandom);
          rt = DW'($urandom);
          wt = DW'($urandom);
        end
      endcase
      set_timing(ht, rt, wt);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      pause_at = $urandom_range(20, PHASE_LEN - 20);
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (i == pause_at) drain();
        send_access(rand_access());
      end
    end

    // Back-to-back costly read misses at the largest timing values.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_timing('1, '1, '1);
    for (int i = 0; i < 64; i++) begin
      send_access(make_access(sacf_pkg::FUNC_READ, TAG_W'($urandom), SET_W'($urandom),
                              OFF_W'($urandom)));
    end
    for (int i = 0; i < 8; i++) send_access(rand_access());

    drain();
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

endmodule

### files.f
sv/sacf_pkg.sv
sv/sacf_ctrl.sv
sv/sacf_datapath.sv
sv/set_assoc_cache_fifo_timing.sv
sv/sacf_checker.sv
tb/sv/tb_top.sv
